FILE: rtl/crcfrd_pkg.sv
// Shared types, constants and functions of the CRC framed record decoder.
// Depends on nothing; every other file of the decoder uses it.
`default_nettype none

package crcfrd_pkg;

	localparam int unsigned HDR_BYTES = 16;
	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;

	// Header byte offsets.
	localparam logic [3:0] OFS_VERSION   = 4'd4;
	localparam logic [3:0] OFS_OPERATION = 4'd5;
	localparam logic [3:0] OFS_KEY_LAST  = 4'd11;
	localparam logic [3:0] OFS_HDR_LAST  = 4'd15;

	// Configuration register indexes.
	localparam int unsigned  CFG_IDX_W        = 3;
	localparam logic [2:0]   REG_FORMAT_VER   = 3'd0;
	localparam logic [2:0]   REG_PUT_CODE     = 3'd1;
	localparam logic [2:0]   REG_DELETE_CODE  = 3'd2;
	localparam logic [2:0]   REG_MAX_KEY_LEN  = 3'd3;
	localparam logic [2:0]   REG_MAX_VAL_LEN  = 3'd4;

	// Configuration reset values.
	localparam logic [7:0]  RST_FORMAT_VER  = 8'd1;
	localparam logic [7:0]  RST_PUT_CODE    = 8'd1;
	localparam logic [7:0]  RST_DELETE_CODE = 8'd2;
	localparam logic [31:0] RST_MAX_KEY_LEN = 32'd1024;
	localparam logic [31:0] RST_MAX_VAL_LEN = 32'd65536;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_MAGIC      = 4'd1,
		ST_VERSION    = 4'd2,
		ST_OPERATION  = 4'd3,
		ST_RESERVED   = 4'd4,
		ST_KEY        = 4'd5,
		ST_VALUE      = 4'd6,
		ST_TOMBSTONE  = 4'd7,
		ST_CHECKSUM   = 4'd8,
		ST_INCOMPLETE = 4'd9
	} status_t;

	typedef enum logic {
		OP_PUT    = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef struct packed {
		logic [7:0]  format_version;
		logic [7:0]  put_code;
		logic [7:0]  delete_code;
		logic [31:0] max_key_len;
		logic [31:0] max_val_len;
	} cfg_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        payload_is_value;
		logic        record_done;
		status_t     status;
		op_t         operation;
		logic [31:0] key_len;
		logic [31:0] val_len;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0: m = 8'h4D;
			2'd1: m = 8'h4B;
			2'd2: m = 8'h56;
			default: m = 8'h52;
		endcase
		return m;
	endfunction

	// One byte of the reflected CRC-32; flattens to an XOR network.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/crcfrd_ifs.sv
// Channel interfaces of the CRC framed record decoder: byte input,
// result output and configuration write. Depends on crcfrd_pkg.
`default_nettype none

interface crcfrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_end;

	modport source (output valid, output data_byte, output buffer_end, input ready);
	modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface crcfrd_out_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        payload_is_value;
	logic        record_done;
	logic [3:0]  status;
	logic        operation;
	logic [31:0] key_len;
	logic [31:0] val_len;

	modport source (output valid, output payload_valid, output payload_byte,
		output payload_is_value, output record_done, output status, output operation,
		output key_len, output val_len, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input payload_is_value, input record_done, input status, input operation,
		input key_len, input val_len, output ready);
endinterface

interface crcfrd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [crcfrd_pkg::CFG_IDX_W-1:0]   index;
	logic [31:0]                        data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/crcfrd_cfg_regs.sv
// Configuration register file of the record decoder.
// Depends on crcfrd_pkg and the crcfrd_cfg_if interface.
`default_nettype none

module crcfrd_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	crcfrd_cfg_if.sink         cfg,
	output crcfrd_pkg::cfg_t   regs
);

	crcfrd_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.format_version <= crcfrd_pkg::RST_FORMAT_VER;
			regs_q.put_code       <= crcfrd_pkg::RST_PUT_CODE;
			regs_q.delete_code    <= crcfrd_pkg::RST_DELETE_CODE;
			regs_q.max_key_len    <= crcfrd_pkg::RST_MAX_KEY_LEN;
			regs_q.max_val_len    <= crcfrd_pkg::RST_MAX_VAL_LEN;
		end else if (cfg.valid) begin
			case (cfg.index)
				crcfrd_pkg::REG_FORMAT_VER:  regs_q.format_version <= cfg.data[7:0];
				crcfrd_pkg::REG_PUT_CODE:    regs_q.put_code       <= cfg.data[7:0];
				crcfrd_pkg::REG_DELETE_CODE: regs_q.delete_code    <= cfg.data[7:0];
				crcfrd_pkg::REG_MAX_KEY_LEN: regs_q.max_key_len    <= cfg.data;
				crcfrd_pkg::REG_MAX_VAL_LEN: regs_q.max_val_len    <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/crc_framed_record_decoder_unit.sv
// Top level of the CRC framed record decoder: byte input register, header
// checks, CRC step, record state and result register. Depends on
// crcfrd_pkg, crcfrd_ifs and crcfrd_cfg_regs.
//
//  channel   direction  handshake      carries
//  rec_in    in         valid/ready    data_byte, buffer_end
//  rec_out   out        valid/ready    payload and record report fields
//  cfg       in         valid/ready    index, data (always ready)
//
// One byte per cycle sustained while rec_out is not stalled; the result of a byte
// passes through the input register, then the result register.
// The record state and the CRC are updated as a byte leaves the input register.
// Reset clears the record state and loads the register defaults at once.
// A stall on rec_out holds the byte in the input register; bytes that give no
// result still drain only when the result register can move.
`default_nettype none

module crc_framed_record_decoder_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	crcfrd_in_if.sink   rec_in,
	crcfrd_out_if.source rec_out,
	crcfrd_cfg_if.sink  cfg
);

	crcfrd_pkg::cfg_t regs;

	crcfrd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Record state.
	logic [33:0]           pos_q;
	logic [31:0]           crc_q;
	logic [31:0]           key_len_q;
	logic [31:0]           val_len_q;
	logic [31:0]           rcv_crc_q;
	crcfrd_pkg::status_t   err_q;
	crcfrd_pkg::op_t       op_q;
	logic                  disc_q;
	logic [1:0]            ck_q;
	logic [32:0]           key_end_q;
	logic [33:0]           crc_start_q;

	// Result register.
	logic                  out_valid_q;
	crcfrd_pkg::res_t      res_q;

	logic step_fire;
	logic in_hdr;

	// Header field results for this byte.
	logic [31:0]           klen_n;
	logic [31:0]           vlen_n;
	crcfrd_pkg::status_t   err_n;
	crcfrd_pkg::op_t       op_n;
	logic [31:0]           rc_n;

	// Next state.
	logic [33:0]           pos_d;
	logic [31:0]           crc_d;
	logic                  disc_d;
	logic [1:0]            ck_d;
	logic                  restart;
	logic                  res_valid;
	crcfrd_pkg::res_t      res;

	assign step_fire    = valid_s1 && (!out_valid_q || rec_out.ready);
	assign rec_in.ready = !valid_s1 || step_fire;
	assign in_hdr       = (pos_q[33:4] == '0);

	always_comb begin
		klen_n = key_len_q;
		vlen_n = val_len_q;
		err_n  = err_q;
		op_n   = op_q;
		rc_n   = rcv_crc_q;
		rc_n[{ck_q, 3'b000} +: 8] = byte_s1;
		if (in_hdr) begin
			case (pos_q[3:0])
				4'd0, 4'd1, 4'd2, 4'd3: begin
					if (byte_s1 != crcfrd_pkg::magic_byte(pos_q[1:0])
						&& err_n == crcfrd_pkg::ST_OK)
						err_n = crcfrd_pkg::ST_MAGIC;
				end
				crcfrd_pkg::OFS_VERSION: begin
					if (byte_s1 != regs.format_version && err_n == crcfrd_pkg::ST_OK)
						err_n = crcfrd_pkg::ST_VERSION;
				end
				crcfrd_pkg::OFS_OPERATION: begin
					if (byte_s1 == regs.put_code)
						op_n = crcfrd_pkg::OP_PUT;
					else if (byte_s1 == regs.delete_code)
						op_n = crcfrd_pkg::OP_DELETE;
					else if (err_n == crcfrd_pkg::ST_OK)
						err_n = crcfrd_pkg::ST_OPERATION;
				end
				4'd6, 4'd7: begin
					if (byte_s1 != 8'd0 && err_n == crcfrd_pkg::ST_OK)
						err_n = crcfrd_pkg::ST_RESERVED;
				end
				4'd8, 4'd9, 4'd10, crcfrd_pkg::OFS_KEY_LAST: begin
					klen_n[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
					if (pos_q[3:0] == crcfrd_pkg::OFS_KEY_LAST
						&& klen_n > regs.max_key_len && err_n == crcfrd_pkg::ST_OK)
						err_n = crcfrd_pkg::ST_KEY;
				end
				default: begin
					vlen_n[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
					if (pos_q[3:0] == crcfrd_pkg::OFS_HDR_LAST) begin
						if (vlen_n > regs.max_val_len && err_n == crcfrd_pkg::ST_OK)
							err_n = crcfrd_pkg::ST_VALUE;
						if (op_n == crcfrd_pkg::OP_DELETE && vlen_n != 32'd0
							&& err_n == crcfrd_pkg::ST_OK)
							err_n = crcfrd_pkg::ST_TOMBSTONE;
					end
				end
			endcase
		end
	end

	always_comb begin
		pos_d     = pos_q;
		crc_d     = crc_q;
		disc_d    = disc_q;
		ck_d      = ck_q;
		restart   = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		// Header fields go out with every report once the header is complete.
		res.operation = op_n;
		res.key_len   = klen_n;
		res.val_len   = vlen_n;
		if (disc_q) begin
			restart = end_s1;
		end else if (in_hdr) begin
			crc_d = crcfrd_pkg::crc_byte(crc_q, byte_s1);
			if (pos_q[3:0] == crcfrd_pkg::OFS_HDR_LAST) begin
				if (err_n != crcfrd_pkg::ST_OK) begin
					res_valid       = 1'b1;
					res.record_done = 1'b1;
					res.status      = err_n;
					if (end_s1)
						restart = 1'b1;
					else
						disc_d = 1'b1;
				end else if (end_s1) begin
					res_valid       = 1'b1;
					res.record_done = 1'b1;
					res.status      = crcfrd_pkg::ST_INCOMPLETE;
					restart         = 1'b1;
				end else begin
					pos_d = pos_q + 34'd1;
				end
			end else if (end_s1) begin
				// Header cut short: nothing of it is reported.
				res_valid       = 1'b1;
				res.record_done = 1'b1;
				res.status      = crcfrd_pkg::ST_INCOMPLETE;
				res.operation   = crcfrd_pkg::OP_PUT;
				res.key_len     = '0;
				res.val_len     = '0;
				restart         = 1'b1;
			end else begin
				pos_d = pos_q + 34'd1;
			end
		end else if (pos_q < crc_start_q) begin
			crc_d                = crcfrd_pkg::crc_byte(crc_q, byte_s1);
			res_valid            = 1'b1;
			res.payload_valid    = 1'b1;
			res.payload_byte     = byte_s1;
			res.payload_is_value = (pos_q >= {1'b0, key_end_q});
			res.record_done      = end_s1;
			res.status           = end_s1 ? crcfrd_pkg::ST_INCOMPLETE : crcfrd_pkg::ST_OK;
			if (end_s1)
				restart = 1'b1;
			else
				pos_d = pos_q + 34'd1;
		end else if (ck_q == 2'd3) begin
			res_valid       = 1'b1;
			res.record_done = 1'b1;
			res.status      = ((crc_q ^ crcfrd_pkg::CRC_ONES) == rc_n)
				? crcfrd_pkg::ST_OK : crcfrd_pkg::ST_CHECKSUM;
			if (res.status == crcfrd_pkg::ST_CHECKSUM && !end_s1)
				disc_d = 1'b1;
			else
				restart = 1'b1;
		end else if (end_s1) begin
			res_valid       = 1'b1;
			res.record_done = 1'b1;
			res.status      = crcfrd_pkg::ST_INCOMPLETE;
			restart         = 1'b1;
		end else begin
			pos_d = pos_q + 34'd1;
			ck_d  = ck_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rec_in.valid && rec_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (step_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_in.valid && rec_in.ready) begin
			byte_s1 <= rec_in.data_byte;
			end_s1  <= rec_in.buffer_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= crcfrd_pkg::CRC_ONES;
			key_len_q <= '0;
			val_len_q <= '0;
			rcv_crc_q <= '0;
			err_q     <= crcfrd_pkg::ST_OK;
			op_q      <= crcfrd_pkg::OP_PUT;
			disc_q    <= 1'b0;
			ck_q      <= '0;
		end else if (step_fire) begin
			if (restart) begin
				pos_q     <= '0;
				crc_q     <= crcfrd_pkg::CRC_ONES;
				key_len_q <= '0;
				val_len_q <= '0;
				rcv_crc_q <= '0;
				err_q     <= crcfrd_pkg::ST_OK;
				op_q      <= crcfrd_pkg::OP_PUT;
				disc_q    <= 1'b0;
				ck_q      <= '0;
			end else if (!disc_q) begin
				pos_q     <= pos_d;
				crc_q     <= crc_d;
				key_len_q <= klen_n;
				val_len_q <= vlen_n;
				rcv_crc_q <= in_hdr ? rcv_crc_q : rc_n;
				err_q     <= err_n;
				op_q      <= op_n;
				disc_q    <= disc_d;
				ck_q      <= ck_d;
			end
		end
	end

	// Payload boundaries, formed once from the header so the byte path
	// only compares against them.
	always_ff @(posedge clk) begin
		if (step_fire && !disc_q && in_hdr) begin
			if (pos_q[3:0] == crcfrd_pkg::OFS_KEY_LAST)
				key_end_q <= 33'(crcfrd_pkg::HDR_BYTES) + {1'b0, klen_n};
			if (pos_q[3:0] == crcfrd_pkg::OFS_HDR_LAST)
				crc_start_q <= {1'b0, key_end_q} + {2'b00, vlen_n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || rec_out.ready) begin
			out_valid_q <= step_fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire && res_valid)
			res_q <= res;
	end

	assign rec_out.valid            = out_valid_q;
	assign rec_out.payload_valid    = res_q.payload_valid;
	assign rec_out.payload_byte     = res_q.payload_byte;
	assign rec_out.payload_is_value = res_q.payload_is_value;
	assign rec_out.record_done      = res_q.record_done;
	assign rec_out.status           = res_q.status;
	assign rec_out.operation        = res_q.operation;
	assign rec_out.key_len          = res_q.key_len;
	assign rec_out.val_len          = res_q.val_len;

	// While discarding, bytes are swallowed without any result.
	a_disc_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(step_fire && disc_q) |-> !res_valid)
		else $error("result produced while discarding");

	// A header error is only ever held while the header is being read.
	a_err_in_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != crcfrd_pkg::ST_OK) |-> in_hdr)
		else $error("header error held outside the header");

	// The checksum byte counter only runs past the payload.
	a_ck_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(ck_q != 2'd0) |-> (!in_hdr && pos_q >= crc_start_q))
		else $error("checksum counter active before checksum bytes");

	// A payload result carries either no report or an incomplete report.
	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.payload_valid) |->
			(res_q.record_done ? (res_q.status == crcfrd_pkg::ST_INCOMPLETE)
				: (res_q.status == crcfrd_pkg::ST_OK)))
		else $error("bad status on payload result");

	// A byte that leaves the input register while a result waits must mean
	// the waiting result was taken in the same cycle.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(step_fire && out_valid_q) |-> rec_out.ready)
		else $error("result register overwritten");

endmodule

`default_nettype wire
